/* hdl/yb_pkg.sv */
package yb_pkg;

  // Configuration port widths and register indexes.
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_COLOR_MATRIX  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_FORMAT = 8'd1;

  // Register codes.
  localparam logic MATRIX_BT601   = 1'b0;
  localparam logic MATRIX_BT709   = 1'b1;
  localparam logic FORMAT_BGRA    = 1'b0;
  localparam logic FORMAT_YUV     = 1'b1;

  // Fixed-point widths.
  localparam int LUMA_TERM_W = 17;  // 239 * 298 fits in 17 bits
  localparam int CHROMA_TERM_W = 18;  // signed, up to 541 * 128
  localparam int SUM_W = 20;  // signed channel sum before the shift

  localparam logic [7:0]  LUMA_FLOOR = 8'd16;
  localparam logic [16:0] LUMA_SCALE = 17'd298;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = 20'sd128;

  typedef struct packed {
    logic [9:0] kb;
    logic [9:0] kgb;
    logic [9:0] kgr;
    logic [9:0] kr;
  } coef_set_t;

  localparam coef_set_t COEF_BT601 = '{kb: 10'd516, kgb: 10'd100, kgr: 10'd208, kr: 10'd409};
  localparam coef_set_t COEF_BT709 = '{kb: 10'd541, kgb: 10'd55, kgr: 10'd136, kr: 10'd459};

  // Chroma contributions shared by both pixels of a pair.
  typedef struct packed {
    logic signed [CHROMA_TERM_W-1:0] b;
    logic signed [CHROMA_TERM_W-1:0] g;
    logic signed [CHROMA_TERM_W-1:0] r;
  } chroma_terms_t;

  // Signed chroma sample times an unsigned coefficient.
  function automatic logic signed [CHROMA_TERM_W-1:0] mul_coef(
      input logic signed [7:0] c, input logic [9:0] k);
    logic signed [CHROMA_TERM_W-1:0] a;
    logic signed [CHROMA_TERM_W-1:0] m;
    a = {{(CHROMA_TERM_W-8){c[7]}}, c};
    m = {{(CHROMA_TERM_W-10){1'b0}}, k};
    return a * m;
  endfunction

endpackage

/* hdl/yb_pixel.sv */
// Forms the three channel sums of one pixel, shifts and clamps them,
// and packs the BGRA word with an opaque alpha.
module yb_pixel (
  input  logic [yb_pkg::LUMA_TERM_W-1:0] luma_term,
  input  yb_pkg::chroma_terms_t          terms,
  output logic [31:0]                    pixel
);

  logic signed [yb_pkg::SUM_W-1:0] luma_ext;
  logic signed [yb_pkg::SUM_W-1:0] sum_b;
  logic signed [yb_pkg::SUM_W-1:0] sum_g;
  logic signed [yb_pkg::SUM_W-1:0] sum_r;

  function automatic logic [7:0] clamp_chan(input logic signed [yb_pkg::SUM_W-1:0] s);
    logic [7:0] c;
    if (s[yb_pkg::SUM_W-1]) begin
      c = 8'd0;
    end else if (|s[yb_pkg::SUM_W-2:16]) begin
      c = 8'hFF;
    end else begin
      c = s[15:8];
    end
    return c;
  endfunction

  assign luma_ext = {{(yb_pkg::SUM_W-yb_pkg::LUMA_TERM_W){1'b0}}, luma_term};

  always_comb begin
    sum_b = luma_ext + yb_pkg::SUM_W'(terms.b) + yb_pkg::ROUND_HALF;
    sum_g = luma_ext + yb_pkg::SUM_W'(terms.g) + yb_pkg::ROUND_HALF;
    sum_r = luma_ext + yb_pkg::SUM_W'(terms.r) + yb_pkg::ROUND_HALF;
    pixel = {yb_pkg::ALPHA_OPAQUE, clamp_chan(sum_r), clamp_chan(sum_g), clamp_chan(sum_b)};
  end

endmodule

/* hdl/yuv_to_bgra_pixel_pair.sv */
// YUV to BGRA converter for horizontally adjacent pixel pairs.
//
// Input: a pair is transferred at a rising edge where start is high and busy
// is low. busy is always low, so a new pair may be offered in every cycle.
// Each pair carries two luma bytes with one shared u,v chroma pair, plus two
// BGRA words that are used only in passthrough mode.
// Output: done is high for exactly one cycle with pixel_first and
// pixel_second. The receiver cannot stall; results arrive in input order.
// Each pair passes three register stages (input capture, coefficient
// products, clamped result). Throughput is one pair per cycle, since every
// stage takes a new pair at each edge and busy is never raised.
// Configuration: cfg_valid/cfg_ready write register cfg_index with cfg_data
// bit 0. Index 0 is the color matrix (0 BT.601, 1 BT.709) and index 1 the
// source format (0 BGRA passthrough, 1 YUV). Other indexes are ignored.
// cfg_ready is always high. Write registers only while no pair is in flight.
// Reset: synchronous rst empties the pipeline and sets BT.601, YUV mode.
module yuv_to_bgra_pixel_pair (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [7:0]                     luma_first,
  input  logic [7:0]                     luma_second,
  input  logic [7:0]                     chroma_u,
  input  logic [7:0]                     chroma_v,
  input  logic [31:0]                    pass_first,
  input  logic [31:0]                    pass_second,
  output logic                           done,
  output logic [31:0]                    pixel_first,
  output logic [31:0]                    pixel_second,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [yb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [yb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers.
  logic color_matrix;
  logic source_format;

  // Input capture stage.
  logic        in_valid;
  logic [7:0]  in_luma_first;
  logic [7:0]  in_luma_second;
  logic [7:0]  in_u;
  logic [7:0]  in_v;
  logic [31:0] in_pass_first;
  logic [31:0] in_pass_second;
  logic        in_yuv;

  // Product stage.
  logic                           prod_valid;
  logic [yb_pkg::LUMA_TERM_W-1:0] prod_luma_first;
  logic [yb_pkg::LUMA_TERM_W-1:0] prod_luma_second;
  yb_pkg::chroma_terms_t          prod_terms;
  logic [23:0]                    prod_pass_first;
  logic [23:0]                    prod_pass_second;
  logic                           prod_yuv;

  logic                           accept;
  yb_pkg::coef_set_t              coef;
  logic signed [7:0]              cb;
  logic signed [7:0]              cr;
  logic [7:0]                     luma_off_first;
  logic [7:0]                     luma_off_second;
  yb_pkg::chroma_terms_t          terms_next;
  logic [yb_pkg::LUMA_TERM_W-1:0] luma_term_first_next;
  logic [yb_pkg::LUMA_TERM_W-1:0] luma_term_second_next;
  logic [31:0]                    conv_first;
  logic [31:0]                    conv_second;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_matrix  <= yb_pkg::MATRIX_BT601;
      source_format <= yb_pkg::FORMAT_YUV;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        yb_pkg::REG_COLOR_MATRIX:  color_matrix  <= cfg_data[0];
        yb_pkg::REG_SOURCE_FORMAT: source_format <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage 1: capture the pair together with the mode it was accepted in.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_luma_first  <= luma_first;
      in_luma_second <= luma_second;
      in_u           <= chroma_u;
      in_v           <= chroma_v;
      in_pass_first  <= pass_first;
      in_pass_second <= pass_second;
      in_yuv         <= (source_format == yb_pkg::FORMAT_YUV);
    end
  end

  // Stage 2: luma scaling and the chroma products. The chroma terms are
  // shared by both pixels. Flipping the top bit of an offset-128 byte gives
  // its two's complement value minus 128.
  always_comb begin
    coef = (color_matrix == yb_pkg::MATRIX_BT709) ? yb_pkg::COEF_BT709 : yb_pkg::COEF_BT601;
    cb   = {~in_u[7], in_u[6:0]};
    cr   = {~in_v[7], in_v[6:0]};
    luma_off_first  = (in_luma_first < yb_pkg::LUMA_FLOOR) ? 8'd0
                      : in_luma_first - yb_pkg::LUMA_FLOOR;
    luma_off_second = (in_luma_second < yb_pkg::LUMA_FLOOR) ? 8'd0
                      : in_luma_second - yb_pkg::LUMA_FLOOR;
    luma_term_first_next  = {9'd0, luma_off_first} * yb_pkg::LUMA_SCALE;
    luma_term_second_next = {9'd0, luma_off_second} * yb_pkg::LUMA_SCALE;
    terms_next.b = yb_pkg::mul_coef(cb, coef.kb);
    terms_next.g = -(yb_pkg::mul_coef(cb, coef.kgb) + yb_pkg::mul_coef(cr, coef.kgr));
    terms_next.r = yb_pkg::mul_coef(cr, coef.kr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_luma_first  <= luma_term_first_next;
    prod_luma_second <= luma_term_second_next;
    prod_terms       <= terms_next;
    prod_pass_first  <= in_pass_first[23:0];
    prod_pass_second <= in_pass_second[23:0];
    prod_yuv         <= in_yuv;
  end

  // Stage 3: sums, clamping and the passthrough select.
  yb_pixel u_pixel_first (
    .luma_term (prod_luma_first),
    .terms     (prod_terms),
    .pixel     (conv_first)
  );

  yb_pixel u_pixel_second (
    .luma_term (prod_luma_second),
    .terms     (prod_terms),
    .pixel     (conv_second)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_yuv) begin
      pixel_first  <= conv_first;
      pixel_second <= conv_second;
    end else begin
      pixel_first  <= {yb_pkg::ALPHA_OPAQUE, prod_pass_first};
      pixel_second <= {yb_pkg::ALPHA_OPAQUE, prod_pass_second};
    end
  end

  // Every accepted pair comes out as a result once it has passed the pipeline.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 done)
    else $error("accepted pair did not produce a result after three cycles");

  // A result never appears without a matching accepted pair.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 3))
    else $error("result strobe without a matching accepted pair");

  // Both output pixels are opaque in every mode.
  a_alpha: assert property (@(posedge clk) disable iff (rst)
    done |-> (pixel_first[31:24] == yb_pkg::ALPHA_OPAQUE)
             && (pixel_second[31:24] == yb_pkg::ALPHA_OPAQUE))
    else $error("output alpha is not opaque");

endmodule

/* sim/tb_yuv_to_bgra_pixel_pair.sv */
`timescale 1ns / 100ps

// Testbench for the pixel-pair converter. Pairs are offered on the start/busy
// command port with random gaps and back-to-back bursts. Every accepted
// transfer is run through a local predictor at the register settings in
// force, and the expected pixel pair is queued. Each done strobe is then
// checked against the oldest queued pair.
module tb_yuv_to_bgra_pixel_pair;

  // Fixed-point coefficients of the two color matrices.
  localparam int LUMA_OFFSET = 16;
  localparam int LUMA_GAIN = 298;
  localparam int CHROMA_MID = 128;
  localparam int ROUNDING = 128;
  localparam int CHANNEL_MAX = 255;
  localparam int BT601_KB = 516;
  localparam int BT601_KGB = 100;
  localparam int BT601_KGR = 208;
  localparam int BT601_KR = 409;
  localparam int BT709_KB = 541;
  localparam int BT709_KGB = 55;
  localparam int BT709_KGR = 136;
  localparam int BT709_KR = 459;

  // Indexes beyond the register map, used to check that such writes are dropped.
  localparam logic [yb_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 8'd2;
  localparam logic [yb_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED_TOP = 8'hFF;

  localparam int RANDOM_PAIRS = 1130;
  localparam int RANDOM_PHASES = 6;
  localparam int BURST_LEN = 32;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [31:0] first;
    logic [31:0] second;
  } pixel_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [7:0] luma_first = '0;
  logic [7:0] luma_second = '0;
  logic [7:0] chroma_u = '0;
  logic [7:0] chroma_v = '0;
  logic [31:0] pass_first = '0;
  logic [31:0] pass_second = '0;
  logic done;
  logic [31:0] pixel_first;
  logic [31:0] pixel_second;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [yb_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [yb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Local copies of the two registers, starting at their reset values.
  logic matrix_sel = yb_pkg::MATRIX_BT601;
  logic format_sel = yb_pkg::FORMAT_YUV;

  // Pixel pairs still owed by the block, oldest first.
  pixel_pair_t owed_pairs[$];

  // These track what was last scheduled on start and cfg_valid, so that a
  // signal is lowered only when it is actually high.
  bit pair_offered = 0;
  bit write_offered = 0;
  bit burst_mode = 0;

  int mismatches = 0;
  int pairs_sent = 0;
  int pairs_checked = 0;
  int writes_done = 0;
  int ycc_pairs = 0;
  int bgra_pairs = 0;

  yuv_to_bgra_pixel_pair dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .luma_first(luma_first),
    .luma_second(luma_second),
    .chroma_u(chroma_u),
    .chroma_v(chroma_v),
    .pass_first(pass_first),
    .pass_second(pass_second),
    .done(done),
    .pixel_first(pixel_first),
    .pixel_second(pixel_second),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block stops answering.
  initial begin
    #2000000;
    $display("FAIL yuv_to_bgra_pixel_pair");
    $finish;
  end

  // Channel sums are floored by the shift; negative sums give zero and
  // anything past 255 saturates.
  function automatic logic [7:0] clamp_channel(input int sum);
    int scaled;
    if (sum < 0) begin
      return 8'd0;
    end
    scaled = sum >>> 8;
    if (scaled > CHANNEL_MAX) begin
      return 8'hFF;
    end
    return scaled[7:0];
  endfunction

  // One pixel through the color matrix. Luma below the black level is
  // pinned to black before scaling.
  function automatic logic [31:0] ycc_to_bgra(input logic [7:0] y, input logic [7:0] u,
                                              input logic [7:0] v, input logic bt709);
    int luma;
    int cb;
    int cr;
    int kb;
    int kgb;
    int kgr;
    int kr;
    luma = int'(y) - LUMA_OFFSET;
    if (luma < 0) begin
      luma = 0;
    end
    luma = luma * LUMA_GAIN;
    cb = int'(u) - CHROMA_MID;
    cr = int'(v) - CHROMA_MID;
    kb = (bt709 == yb_pkg::MATRIX_BT709) ? BT709_KB : BT601_KB;
    kgb = (bt709 == yb_pkg::MATRIX_BT709) ? BT709_KGB : BT601_KGB;
    kgr = (bt709 == yb_pkg::MATRIX_BT709) ? BT709_KGR : BT601_KGR;
    kr = (bt709 == yb_pkg::MATRIX_BT709) ? BT709_KR : BT601_KR;
    return {yb_pkg::ALPHA_OPAQUE,
            clamp_channel(luma + kr * cr + ROUNDING),
            clamp_channel(luma - kgb * cb - kgr * cr + ROUNDING),
            clamp_channel(luma + kb * cb + ROUNDING)};
  endfunction

  // Expected output pair for one input pair at the current settings.
  function automatic pixel_pair_t convert_pair(input logic [7:0] y0, input logic [7:0] y1,
                                              input logic [7:0] u, input logic [7:0] v,
                                              input logic [31:0] p0, input logic [31:0] p1);
    pixel_pair_t pair;
    if (format_sel == yb_pkg::FORMAT_BGRA) begin
      pair.first = {yb_pkg::ALPHA_OPAQUE, p0[23:0]};
      pair.second = {yb_pkg::ALPHA_OPAQUE, p1[23:0]};
    end else begin
      pair.first = ycc_to_bgra(y0, u, v, matrix_sel);
      pair.second = ycc_to_bgra(y1, u, v, matrix_sel);
    end
    return pair;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Result checker. done, pixel_first and pixel_second are read at the edge
  // that ends the strobe cycle, before any register there updates, so the
  // values seen are the ones the block presented during that cycle.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (owed_pairs.size() == 0) begin
        report_mismatch($sformatf("unexpected result %08h %08h", pixel_first, pixel_second));
      end else begin
        pixel_pair_t want;
        want = owed_pairs.pop_front();
        pairs_checked++;
        if (pixel_first !== want.first) begin
          report_mismatch($sformatf("pair %0d pixel_first %08h, expected %08h",
                                    pairs_checked, pixel_first, want.first));
        end
        if (pixel_second !== want.second) begin
          report_mismatch($sformatf("pair %0d pixel_second %08h, expected %08h",
                                    pairs_checked, pixel_second, want.second));
        end
      end
    end
  end

  // Offers one pair and returns at the edge where it transferred, leaving
  // start high so the next call can follow back to back. The random gap
  // before each pair moves idle cycles across every pipeline stage; in
  // burst mode there are none.
  task automatic send_pair(input logic [7:0] y0, input logic [7:0] y1, input logic [7:0] u,
                           input logic [7:0] v, input logic [31:0] p0, input logic [31:0] p1);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 4);
    if (write_offered) begin
      cfg_valid <= 1'b0;
      write_offered = 0;
    end
    if (gap != 0) begin
      if (pair_offered) begin
        start <= 1'b0;
        pair_offered = 0;
      end
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    pair_offered = 1;
    luma_first <= y0;
    luma_second <= y1;
    chroma_u <= u;
    chroma_v <= v;
    pass_first <= p0;
    pass_second <= p1;
    do @(posedge clk); while (busy);
    owed_pairs.push_back(convert_pair(y0, y1, u, v, p0, p1));
    pairs_sent++;
    if (format_sel == yb_pkg::FORMAT_BGRA) begin
      bgra_pairs++;
    end else begin
      ycc_pairs++;
    end
  endtask

  // Stops offering pairs and waits until every owed pair has come back.
  // Each pair yields exactly one result, so an empty queue means the
  // pipeline is empty as well.
  task automatic wait_drained();
    if (pair_offered) begin
      start <= 1'b0;
      pair_offered = 0;
    end
    while (owed_pairs.size() != 0) @(posedge clk);
  endtask

  // Register write on the configuration channel, only with the pipeline
  // empty. cfg_valid stays up after the transfer until the next pair or
  // write replaces it; repeating the same write has no effect.
  task automatic write_register(input logic [yb_pkg::CFG_INDEX_W-1:0] index,
                                input logic [yb_pkg::CFG_DATA_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    write_offered = 1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    writes_done++;
    // Only bit 0 is kept, and unmapped indexes are dropped.
    if (index == yb_pkg::REG_COLOR_MATRIX) begin
      matrix_sel = value[0];
    end else if (index == yb_pkg::REG_SOURCE_FORMAT) begin
      format_sel = value[0];
    end
  endtask

  // Byte source for the random part: mostly uniform, with a share of the
  // values that sit on the black level and the clamp boundaries.
  function automatic logic [7:0] random_byte();
    logic [7:0] corners[6];
    corners = '{8'd0, 8'd15, 8'd16, 8'd128, 8'd235, 8'd255};
    if ($urandom_range(0, 7) == 0) begin
      return corners[$urandom_range(0, 5)];
    end
    return 8'($urandom);
  endfunction

  task automatic send_random_pair();
    send_pair(random_byte(), random_byte(), random_byte(), random_byte(),
              $urandom, $urandom);
  endtask

  // Straight out of reset the block must convert YUV with BT.601, so no
  // register is written first. The pairs hit full black and white, luma
  // under the black level, and chroma that drives channel sums both below
  // zero and past the top of the range.
  task automatic ycc_corner_pairs();
    send_pair(8'd0, 8'd255, 8'd128, 8'd128, $urandom, $urandom);
    send_pair(8'd15, 8'd16, 8'd128, 8'd128, $urandom, $urandom);
    send_pair(8'd16, 8'd16, 8'd0, 8'd0, $urandom, $urandom);
    send_pair(8'd255, 8'd255, 8'd255, 8'd255, $urandom, $urandom);
    send_pair(8'd255, 8'd0, 8'd0, 8'd255, $urandom, $urandom);
    send_pair(8'd0, 8'd255, 8'd255, 8'd0, $urandom, $urandom);
    send_pair(8'd128, 8'd235, 8'd90, 8'd240, $urandom, $urandom);
  endtask

  task automatic test_reset_defaults();
    ycc_corner_pairs();
  endtask

  task automatic test_bt709_matrix();
    write_register(yb_pkg::REG_COLOR_MATRIX, {31'd0, yb_pkg::MATRIX_BT709});
    ycc_corner_pairs();
  endtask

  // Passthrough must force alpha opaque whatever it was and leave blue,
  // green and red untouched. Luma and chroma are random and must not matter.
  task automatic test_bgra_passthrough();
    write_register(yb_pkg::REG_SOURCE_FORMAT, {31'd0, yb_pkg::FORMAT_BGRA});
    send_pair(random_byte(), random_byte(), random_byte(), random_byte(),
              32'h0000_0000, 32'hFFFF_FFFF);
    send_pair(random_byte(), random_byte(), random_byte(), random_byte(),
              32'h00FF_FFFF, 32'hFF00_0000);
    send_pair(random_byte(), random_byte(), random_byte(), random_byte(),
              32'h5A5A_A5A5, 32'hA5A5_5A5A);
    send_pair(random_byte(), random_byte(), random_byte(), random_byte(),
              $urandom, $urandom);
  endtask

  // Writes to unmapped indexes must leave both registers alone, and only
  // bit 0 of the write data may count.
  task automatic test_register_decode();
    write_register(REG_UNMAPPED, 32'hFFFF_FFFF);
    send_random_pair();
    write_register(REG_UNMAPPED_TOP, 32'hFFFF_FFFF);
    write_register(yb_pkg::REG_SOURCE_FORMAT, {31'h7FFF_FFFF, yb_pkg::FORMAT_YUV});
    send_random_pair();
    write_register(yb_pkg::REG_COLOR_MATRIX, {31'h7FFF_FFFF, yb_pkg::MATRIX_BT601});
    send_random_pair();
    write_register(yb_pkg::REG_COLOR_MATRIX, {31'($urandom), yb_pkg::MATRIX_BT709});
    send_random_pair();
  endtask

  // Random pairs in phases, one register setting per phase. Bursts of
  // back-to-back transfers alternate with stretches of random gaps, and
  // halfway through each phase the sender stops until the pipeline is empty.
  task automatic test_random_stream();
    int per_phase;
    logic [1:0] setting;
    per_phase = RANDOM_PAIRS / RANDOM_PHASES;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      // The first three phases walk BT.601, BT.709 and passthrough in turn;
      // the rest draw a setting at random.
      setting = (phase < 3) ? 2'(phase) : 2'($urandom_range(0, 2));
      write_register(yb_pkg::REG_COLOR_MATRIX,
                     {31'($urandom),
                      (setting == 2'd1) ? yb_pkg::MATRIX_BT709 : yb_pkg::MATRIX_BT601});
      write_register(yb_pkg::REG_SOURCE_FORMAT,
                     {31'($urandom),
                      (setting == 2'd2) ? yb_pkg::FORMAT_BGRA : yb_pkg::FORMAT_YUV});
      if ($urandom_range(0, 1) == 1) begin
        write_register(8'($urandom_range(2, 255)), $urandom);
      end
      for (int i = 0; i < per_phase; i++) begin
        burst_mode = ((i / BURST_LEN) % 2) == 1;
        if (i == per_phase / 2) begin
          wait_drained();
        end
        send_random_pair();
      end
      burst_mode = 0;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_bt709_matrix();
    test_bgra_passthrough();
    test_register_decode();
    test_random_stream();

    // Let the last results out, then keep watching for strays.
    wait_drained();
    if (write_offered) begin
      cfg_valid <= 1'b0;
      write_offered = 0;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d of %0d pixel pairs: %0d converted from YUV, %0d passed as BGRA.",
             pairs_checked, pairs_sent, ycc_pairs, bgra_pairs);
    $display("Both color matrices and both source formats used, %0d register writes, %0d %s",
             writes_done, mismatches, "mismatches.");
    if (mismatches == 0 && owed_pairs.size() == 0) begin
      $display("PASS yuv_to_bgra_pixel_pair");
    end else begin
      $display("FAIL yuv_to_bgra_pixel_pair");
    end
    $finish;
  end

endmodule

/* yuv_to_bgra_pixel_pair.f */
hdl/yb_pkg.sv
hdl/yb_pixel.sv
hdl/yuv_to_bgra_pixel_pair.sv
sim/tb_yuv_to_bgra_pixel_pair.sv
